// File: design/plbs_pkg.sv
package plbs_pkg;

    localparam int unsigned DefBookDepth = 16;
    localparam int unsigned PriceW       = 32;
    localparam int unsigned QtyW         = 32;
    localparam int unsigned SeqW         = 64;
    localparam int unsigned TimeW        = 64;

    // One level as it sits in a cell.
    typedef struct packed {
        logic              valid;
        logic [PriceW-1:0] price;
        logic [QtyW-1:0]   qty;
    } level_t;

    // Decision of one cell for the incoming level, handed to its right-hand neighbour.
    typedef struct packed {
        logic ahead;   // this cell's price ranks strictly before the new price
        logic hit;     // this cell or a better one holds the new price
    } cell_flag_t;

    // The update applied to one side in this cycle.
    typedef struct packed {
        logic              apply;
        logic              clear;
        logic              is_ask;
        logic [PriceW-1:0] price;
        logic [QtyW-1:0]   qty;
    } side_cmd_t;

endpackage

// File: design/plbs_cell.sv
module plbs_cell
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  plbs_pkg::side_cmd_t    cmd,
    input  plbs_pkg::cell_flag_t   flag_left,   // decision of the better neighbour
    input  plbs_pkg::level_t       level_left,  // contents of the better neighbour
    input  plbs_pkg::level_t       level_right, // contents of the worse neighbour
    output plbs_pkg::cell_flag_t   flag_here,
    output plbs_pkg::level_t       level_here
);

    logic                          valid_reg, valid_next;
    logic [plbs_pkg::PriceW-1:0]   price_reg, price_next;
    logic [plbs_pkg::QtyW-1:0]     qty_reg, qty_next;
    logic                          v;
    logic                          ahead;
    logic                          match_here;

    // A clear on this request empties the cell before the level is applied.
    assign v          = valid_reg && !cmd.clear;
    assign ahead      = v && (cmd.is_ask ? (price_reg < cmd.price)
                                         : (price_reg > cmd.price));
    assign match_here = v && (price_reg == cmd.price);

    always_comb
    begin
        flag_here.ahead  = ahead;
        flag_here.hit    = flag_left.hit || match_here;
        level_here.valid = v;
        level_here.price = price_reg;
        level_here.qty   = qty_reg;
    end

    always_comb
    begin
        valid_next = v;
        price_next = price_reg;
        qty_next   = qty_reg;
        if (cmd.apply && !ahead)
        begin
            if (match_here)
            begin
                if (cmd.qty == '0)
                begin
                    valid_next = level_right.valid;     // removal: close the gap
                    price_next = level_right.price;
                    qty_next   = level_right.qty;
                end
                else
                begin
                    qty_next = cmd.qty;
                end
            end
            else if (flag_left.hit)
            begin
                if (cmd.qty == '0)
                begin
                    valid_next = level_right.valid;     // behind a removed level
                    price_next = level_right.price;
                    qty_next   = level_right.qty;
                end
            end
            else if (cmd.qty != '0)
            begin
                if (flag_left.ahead)
                begin
                    valid_next = 1'b1;                  // insertion point
                    price_next = cmd.price;
                    qty_next   = cmd.qty;
                end
                else
                begin
                    valid_next = level_left.valid;      // shift down by one
                    price_next = level_left.price;
                    qty_next   = level_left.qty;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        price_reg <= price_next;
        qty_reg   <= qty_next;
    end

endmodule

// File: design/plbs_side.sv
module plbs_side
#(
    parameter int unsigned BOOK_DEPTH = plbs_pkg::DefBookDepth
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  plbs_pkg::side_cmd_t cmd,
    output plbs_pkg::level_t    best,
    output logic                overflow
);

    plbs_pkg::level_t     lvl  [BOOK_DEPTH+1];
    plbs_pkg::cell_flag_t flg  [BOOK_DEPTH+1];
    plbs_pkg::level_t     lefl [BOOK_DEPTH];

    // The best cell always sees an insertion point on its left and no held price.
    assign flg[0].ahead    = 1'b1;
    assign flg[0].hit      = 1'b0;
    assign lvl[BOOK_DEPTH] = '0;

    genvar g;
    generate
        for (g = 0; g < BOOK_DEPTH; g++)
        begin : g_cell
            if (g == 0)
            begin : g_first
                assign lefl[g] = '0;
            end
            else
            begin : g_rest
                assign lefl[g] = lvl[g-1];
            end
            plbs_cell u_cell
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .flag_left   (flg[g]),
                .level_left  (lefl[g]),
                .level_right (lvl[g+1]),
                .flag_here   (flg[g+1]),
                .level_here  (lvl[g])
            );
        end
    endgenerate

    assign best     = lvl[0];
    // Full side, new price absent, non-zero quantity: evict or drop.
    assign overflow = cmd.apply && (cmd.qty != '0) && lvl[BOOK_DEPTH-1].valid
                   && !flg[BOOK_DEPTH].hit;

endmodule

// File: design/price_level_book_sides_unit.sv
// Channel | Ports                 | Carries
// input   | in_valid / in_ready   | one level update request
// output  | out_valid / out_ready | best bid, best ask, latched update, overflow
//
// Each request is applied at its acceptance edge to a row of BOOK_DEPTH cells per side;
// every cell compares the new price with its own and shifts, inserts or closes a gap.
// The result register is loaded on the next edge, and in_ready is low until then, so no
// new request is taken while one is in flight and its best levels are not yet sampled.
// Reset empties both sides and clears the sequence and time held for the next result.
// A stalled output holds its result and keeps in_ready low until the result is taken.
module price_level_book_sides_unit
#(
    parameter int unsigned BOOK_DEPTH = plbs_pkg::DefBookDepth
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        book_side,
    input  logic        carries_level,
    input  logic [31:0] level_price,
    input  logic [31:0] level_qty,
    input  logic        clear_book,
    input  logic        end_of_update,
    input  logic [63:0] update_seq,
    input  logic signed [63:0] update_time_ns,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        bid_valid,
    output logic [31:0] best_bid_price,
    output logic [31:0] best_bid_qty,
    output logic        ask_valid,
    output logic [31:0] best_ask_price,
    output logic [31:0] best_ask_qty,
    output logic [63:0] latched_seq,
    output logic signed [63:0] latched_time_ns,
    output logic        overflowed
);

    // Both sides are updated at the acceptance edge; the result register then
    // samples the new best levels at the next edge, which a pending flag marks.
    logic                take;
    plbs_pkg::side_cmd_t bid_cmd, ask_cmd;
    plbs_pkg::level_t    bid_best, ask_best;
    logic                bid_ovf, ask_ovf;
    logic                pend_reg, pend_next;
    logic                ovf_reg, ovf_next;
    logic                out_valid_reg, out_valid_next;
    logic [63:0]         seq_reg, seq_next;
    logic [63:0]         time_reg, time_next;

    assign in_ready = !pend_reg && (!out_valid_reg || out_ready);
    assign take     = in_valid && in_ready;

    always_comb
    begin
        bid_cmd.apply  = take && carries_level && !book_side;
        bid_cmd.clear  = take && clear_book;
        bid_cmd.is_ask = 1'b0;
        bid_cmd.price  = level_price;
        bid_cmd.qty    = level_qty;
        ask_cmd.apply  = take && carries_level && book_side;
        ask_cmd.clear  = take && clear_book;
        ask_cmd.is_ask = 1'b1;
        ask_cmd.price  = level_price;
        ask_cmd.qty    = level_qty;
    end

    plbs_side #(.BOOK_DEPTH(BOOK_DEPTH)) u_bid
    (
        .clk(clk), .rst_n(rst_n), .cmd(bid_cmd), .best(bid_best), .overflow(bid_ovf)
    );

    plbs_side #(.BOOK_DEPTH(BOOK_DEPTH)) u_ask
    (
        .clk(clk), .rst_n(rst_n), .cmd(ask_cmd), .best(ask_best), .overflow(ask_ovf)
    );

    always_comb
    begin
        pend_next      = take;
        ovf_next       = take ? (bid_ovf | ask_ovf) : ovf_reg;
        seq_next       = (take && end_of_update) ? update_seq : seq_reg;
        time_next      = (take && end_of_update) ? update_time_ns : time_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pend_reg)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            seq_reg       <= '0;
            time_reg      <= '0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            seq_reg       <= seq_next;
            time_reg      <= time_next;
            ovf_reg       <= ovf_next;
        end
    end

    plbs_pkg::level_t bb_reg, ab_reg;
    logic [63:0]      oseq_reg;
    logic [63:0]      otime_reg;
    logic             oovf_reg;

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            bb_reg    <= bid_best;
            ab_reg    <= ask_best;
            oseq_reg  <= seq_reg;
            otime_reg <= time_reg;
            oovf_reg  <= ovf_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign bid_valid       = bb_reg.valid;
    assign best_bid_price  = bb_reg.valid ? bb_reg.price : '0;
    assign best_bid_qty    = bb_reg.valid ? bb_reg.qty : '0;
    assign ask_valid       = ab_reg.valid;
    assign best_ask_price  = ab_reg.valid ? ab_reg.price : '0;
    assign best_ask_qty    = ab_reg.valid ? ab_reg.qty : '0;
    assign latched_seq     = oseq_reg;
    assign latched_time_ns = otime_reg;
    assign overflowed      = oovf_reg;

endmodule

// File: design/plbs_checker.sv
module plbs_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        bid_valid,
    input logic [31:0] best_bid_price,
    input logic        ask_valid,
    input logic [31:0] best_ask_price
);

    // A result follows each accepted request.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> ##1 out_valid)
        else $error("no result after request");

    // No new request is taken in the cycle after one was taken.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while one in flight");

    // An empty side shows a zero price.
    a_empty_bid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !bid_valid) |-> best_bid_price == '0)
        else $error("empty bid side shows a price");

    a_empty_ask: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ask_valid) |-> best_ask_price == '0)
        else $error("empty ask side shows a price");

endmodule

bind price_level_book_sides_unit plbs_checker u_plbs_checker
(
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .bid_valid(bid_valid),
    .best_bid_price(best_bid_price), .ask_valid(ask_valid),
    .best_ask_price(best_ask_price)
);
